// ===== rtl/ttrc_pkg.sv =====
`default_nettype none

package ttrc_pkg;

  // Record window layout
  localparam int TEXT_BYTES_DEF = 32;
  localparam int HEADER_BYTES   = 8;
  localparam int MAGIC_BYTES    = 4;

  // Printable ASCII bounds
  localparam logic [7:0] PRINT_LOW  = 8'h20;
  localparam logic [7:0] PRINT_HIGH = 8'h7E;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ABSENT   = 2'd1;
  localparam logic [1:0] ST_FORMAT   = 2'd2;
  localparam logic [1:0] ST_CHECKSUM = 2'd3;

  // Configuration register indexes
  localparam int         CFG_INDEX_W    = 2;
  localparam logic [1:0] CFG_MAGIC      = 2'd0;
  localparam logic [1:0] CFG_CAPACITY   = 2'd1;
  localparam logic [7:0] CAPACITY_RESET = 8'd255;

  // Verdict handed from the scanner to the emitter at the end of a record
  typedef struct packed {
    logic       start;
    logic [1:0] status;
  } verdict_t;

endpackage

`default_nettype wire

// ===== rtl/ttrc_text_ram.sv =====
`default_nettype none

module ttrc_text_ram #(
  parameter int DEPTH  = ttrc_pkg::TEXT_BYTES_DEF,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ttrc_scan.sv =====
`default_nettype none

module ttrc_scan #(
  parameter int TEXT_BYTES = ttrc_pkg::TEXT_BYTES_DEF,
  parameter int ADDR_W     = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic [31:0]       magic_word,
  input  wire logic [7:0]        output_capacity,
  input  wire logic              done,
  output logic                   wr_en,
  output logic      [ADDR_W-1:0] wr_addr,
  output logic      [7:0]        wr_data,
  output ttrc_pkg::verdict_t     verdict,
  output logic      [ADDR_W-1:0] last_idx
);

  localparam int WINDOW_LAST = ttrc_pkg::HEADER_BYTES + TEXT_BYTES;
  localparam int POS_W       = $clog2(WINDOW_LAST + 1);

  logic [POS_W-1:0] byte_position;
  logic             magic_matches;
  logic [31:0]      length_value;
  logic [7:0]       xor_accumulator;
  logic             all_printable;
  logic             busy;

  logic             take;
  logic             at_final;
  logic [POS_W-1:0] text_pos;
  logic             in_text;
  logic [7:0]       want;
  logic             nonprint;
  logic [31:0]      len_m1;
  logic [1:0]       status_next;

  assign in_ready = !busy;
  assign take     = in_valid && in_ready;
  assign at_final = (byte_position == POS_W'(WINDOW_LAST));
  assign text_pos = byte_position - POS_W'(ttrc_pkg::HEADER_BYTES);
  assign in_text  = (byte_position >= POS_W'(ttrc_pkg::HEADER_BYTES)) && !at_final;
  assign want     = magic_word[{byte_position[1:0], 3'b000} +: 8];
  assign nonprint = (data_byte < ttrc_pkg::PRINT_LOW) || (data_byte > ttrc_pkg::PRINT_HIGH);
  assign len_m1   = length_value - 32'd1;
  assign last_idx = len_m1[ADDR_W-1:0];

  assign wr_en   = take && in_text;
  assign wr_addr = text_pos[ADDR_W-1:0];
  assign wr_data = data_byte;

  // First failing check wins
  always_comb begin
    if (output_capacity < 8'd2) begin
      status_next = ttrc_pkg::ST_FORMAT;
    end else if (!magic_matches) begin
      status_next = ttrc_pkg::ST_ABSENT;
    end else if (length_value == 32'd0 || length_value > 32'(TEXT_BYTES)) begin
      status_next = ttrc_pkg::ST_FORMAT;
    end else if (xor_accumulator != data_byte) begin
      status_next = ttrc_pkg::ST_CHECKSUM;
    end else if (!all_printable) begin
      status_next = ttrc_pkg::ST_FORMAT;
    end else if ({1'b0, output_capacity} < (9'(length_value[7:0]) + 9'd1)) begin
      status_next = ttrc_pkg::ST_FORMAT;
    end else begin
      status_next = ttrc_pkg::ST_OK;
    end
  end

  assign verdict.start  = take && at_final;
  assign verdict.status = status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      magic_matches   <= 1'b1;
      length_value    <= '0;
      xor_accumulator <= '0;
      all_printable   <= 1'b1;
      busy            <= 1'b0;
    end else begin
      if (done) begin
        busy <= 1'b0;
      end
      if (take) begin
        if (at_final) begin
          byte_position   <= '0;
          magic_matches   <= 1'b1;
          length_value    <= '0;
          xor_accumulator <= '0;
          all_printable   <= 1'b1;
          busy            <= 1'b1;
        end else begin
          if (byte_position < POS_W'(ttrc_pkg::MAGIC_BYTES)) begin
            if (data_byte != want) begin
              magic_matches <= 1'b0;
            end
          end else if (!in_text) begin
            // little-endian length lanes
            length_value[{byte_position[1:0], 3'b000} +: 8] <= data_byte;
          end else if ((32'(text_pos) < length_value) && nonprint) begin
            all_printable <= 1'b0;
          end
          xor_accumulator <= xor_accumulator ^ data_byte;
          byte_position   <= byte_position + POS_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ttrc_emit.sv =====
`default_nettype none

module ttrc_emit #(
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ttrc_pkg::verdict_t verdict,
  input  wire logic [ADDR_W-1:0] last_idx,
  output logic                   rd_en,
  output logic      [ADDR_W-1:0] rd_addr,
  input  wire logic [7:0]        rd_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        text_char,
  output logic      [1:0]        status,
  output logic                   last,
  output logic                   done
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SHOW = 1'b1;

  logic              state;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] last_idx_q;
  logic              text_mode;
  logic [1:0]        status_q;
  logic              start_ok;

  assign start_ok  = verdict.start && (verdict.status == ttrc_pkg::ST_OK);
  assign out_valid = (state == ST_SHOW);
  assign last      = !text_mode || (idx == last_idx_q);
  assign done      = out_valid && out_ready && last;
  assign status    = status_q;
  // the RAM read register doubles as the output register
  assign text_char = text_mode ? rd_data : 8'd0;

  // Next read is issued as the current item leaves
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx + ADDR_W'(1);
    case (state)
      ST_IDLE: begin
        if (start_ok) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      ST_SHOW: begin
        rd_en = text_mode && out_ready && (idx != last_idx_q);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (verdict.start) begin
            state <= ST_SHOW;
          end
        end
        ST_SHOW: begin
          if (out_ready && last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && verdict.start) begin
      status_q   <= verdict.status;
      text_mode  <= start_ok;
      idx        <= '0;
      last_idx_q <= last_idx;
    end else if (state == ST_SHOW && out_ready && !last) begin
      idx <= idx + ADDR_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tagged_text_record_checker.sv =====
// Record checker: takes a window of 8 header bytes (magic, little-endian
// length), TEXT_BYTES text bytes and one XOR byte, one byte per cycle, and
// then gives either a single status item (text_char 0, last set) or, when
// every check passes, the first length text bytes with last on the final one.
// Text is held in a one-port-write, one-port-read RAM with registered read
// data; the emitter issues each read as the previous item leaves, so a text
// run streams at one item per cycle when out_ready stays high. in_ready drops
// from the edge that takes the XOR byte until the last result item is taken,
// so the HEADER_BYTES + TEXT_BYTES + 1 input bytes of a record and its result
// items (1 status item, or length text items) never overlap the next record.
// Configuration writes are always taken (cfg_ready is tied high) and belong
// to idle periods between records.
`default_nettype none

module tagged_text_record_checker #(
  parameter int TEXT_BYTES = ttrc_pkg::TEXT_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       data_byte,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [7:0]                       text_char,
  output logic      [1:0]                       status,
  output logic                                  last,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ttrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                      cfg_data
);

  localparam int ADDR_W = (TEXT_BYTES > 1) ? $clog2(TEXT_BYTES) : 1;

  logic [31:0]        magic_word;
  logic [7:0]         output_capacity;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [7:0]         wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_data;
  logic [ADDR_W-1:0]  last_idx;
  logic               done;
  ttrc_pkg::verdict_t verdict;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word      <= '0;
      output_capacity <= ttrc_pkg::CAPACITY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ttrc_pkg::CFG_MAGIC:    magic_word      <= cfg_data;
        ttrc_pkg::CFG_CAPACITY: output_capacity <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  ttrc_scan #(
    .TEXT_BYTES (TEXT_BYTES),
    .ADDR_W     (ADDR_W)
  ) u_scan (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .magic_word      (magic_word),
    .output_capacity (output_capacity),
    .done            (done),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .verdict         (verdict),
    .last_idx        (last_idx)
  );

  ttrc_text_ram #(
    .DEPTH  (TEXT_BYTES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ttrc_emit #(
    .ADDR_W (ADDR_W)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .verdict   (verdict),
    .last_idx  (last_idx),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .text_char (text_char),
    .status    (status),
    .last      (last),
    .done      (done)
  );

endmodule

`default_nettype wire

// ===== rtl/ttrc_checker.sv =====
`default_nettype none

module ttrc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] text_char,
  input wire logic [1:0] status,
  input wire logic       last
);

  // a failed record is a single item
  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ttrc_pkg::ST_OK |-> last)
    else $error("status item without last");

  a_fail_no_text: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ttrc_pkg::ST_OK |-> text_char == 8'd0)
    else $error("status item carries text");

  // only printable text leaves on an ok record
  a_ok_printable: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ttrc_pkg::ST_OK |->
      text_char >= ttrc_pkg::PRINT_LOW && text_char <= ttrc_pkg::PRINT_HIGH)
    else $error("non-printable text item");

  // input is held off while a result run is in flight
  a_no_input_during_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken during result run");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(last))
    else $error("stalled item changed");

endmodule

bind tagged_text_record_checker ttrc_checker u_ttrc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .text_char (text_char),
  .status    (status),
  .last      (last)
);

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_LEN  = ttrc_pkg::TEXT_BYTES_DEF;
  localparam int CHECK_POS = ttrc_pkg::HEADER_BYTES + TEXT_LEN;  // offset of the XOR byte
  localparam logic [7:0] ODD_CHARS [5] = '{8'h00, 8'h1F, 8'h7F, 8'h80, 8'hFF};

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] st;
    logic       fin;
  } text_out_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       data_byte = 8'h00;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [7:0]                       text_char;
  logic [1:0]                       status;
  logic                             last;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [ttrc_pkg::CFG_INDEX_W-1:0] cfg_index = ttrc_pkg::CFG_MAGIC;
  logic [31:0]                      cfg_data = 32'h0;

  // checker copy of the registers and the record scan state
  logic [31:0] chk_magic = 32'h0;
  logic [7:0]  chk_capacity = ttrc_pkg::CAPACITY_RESET;
  int          scan_pos = 0;
  bit          scan_magic_ok = 1'b1;
  logic [31:0] scan_len = 32'h0;
  logic [7:0]  scan_xor = 8'h00;
  bit          scan_printable = 1'b1;
  logic [7:0]  scan_text [TEXT_LEN];

  text_out_t   expected_text_q[$];
  logic [7:0]  record_byte_q[$];

  int          bad_count = 0;
  int          in_gap = 0;
  int          out_wait = 0;
  int          out_stall;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  text_out_t   want;

  tagged_text_record_checker i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .text_char (text_char),
    .status    (status),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_bad(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  // Steps the record scan by one byte; the XOR byte closes the record and
  // queues either the text run or a single status item.
  task automatic scan_record_byte(input logic [7:0] b);
    logic [1:0] code;
    bit         pass;
    int         t;
    if (scan_pos < CHECK_POS) begin
      if (scan_pos < ttrc_pkg::MAGIC_BYTES) begin
        if (b != chk_magic[8*scan_pos +: 8]) scan_magic_ok = 1'b0;
      end else if (scan_pos < ttrc_pkg::HEADER_BYTES) begin
        scan_len[8*(scan_pos-ttrc_pkg::MAGIC_BYTES) +: 8] = b;
      end else begin
        t = scan_pos - ttrc_pkg::HEADER_BYTES;
        scan_text[t] = b;
        if (t < scan_len && (b < ttrc_pkg::PRINT_LOW || b > ttrc_pkg::PRINT_HIGH))
          scan_printable = 1'b0;
      end
      scan_xor ^= b;
      scan_pos++;
    end else begin
      pass = 1'b0;
      code = ttrc_pkg::ST_FORMAT;
      if (chk_capacity < 2) code = ttrc_pkg::ST_FORMAT;
      else if (!scan_magic_ok) code = ttrc_pkg::ST_ABSENT;
      else if (scan_len == 0 || scan_len > TEXT_LEN) code = ttrc_pkg::ST_FORMAT;
      else if (scan_xor != b) code = ttrc_pkg::ST_CHECKSUM;
      else if (!scan_printable) code = ttrc_pkg::ST_FORMAT;
      else if (chk_capacity < scan_len + 1) code = ttrc_pkg::ST_FORMAT;
      else pass = 1'b1;
      if (pass) begin
        for (t = 0; t < scan_len; t++)
          expected_text_q.push_back('{scan_text[t], ttrc_pkg::ST_OK,
                                      1'(t + 1 == scan_len)});
      end else begin
        expected_text_q.push_back('{8'h00, code, 1'b1});
      end
      scan_pos       = 0;
      scan_magic_ok  = 1'b1;
      scan_len       = 32'h0;
      scan_xor       = 8'h00;
      scan_printable = 1'b1;
    end
  endtask

  // Queues one whole record window. Text within the length is printable
  // unless bad_char; text past it is arbitrary.
  task automatic add_record(input logic [31:0] magic, input logic [31:0] len,
                            input bit bad_char, input bit bad_xor);
    logic [7:0] w [CHECK_POS];
    logic [7:0] x;
    int         nlen;
    int         k;
    x = 8'h00;
    for (k = 0; k < ttrc_pkg::MAGIC_BYTES; k++) w[k] = magic[8*k +: 8];
    for (k = 0; k < 4; k++) w[ttrc_pkg::MAGIC_BYTES+k] = len[8*k +: 8];
    nlen = (len > TEXT_LEN) ? TEXT_LEN : int'(len);
    for (k = 0; k < TEXT_LEN; k++) begin
      if (k >= nlen) w[ttrc_pkg::HEADER_BYTES+k] = 8'($urandom);
      else if ($urandom_range(0, 7) == 0)
        w[ttrc_pkg::HEADER_BYTES+k] = $urandom_range(0, 1) ? ttrc_pkg::PRINT_LOW
                                                           : ttrc_pkg::PRINT_HIGH;
      else w[ttrc_pkg::HEADER_BYTES+k] =
          8'($urandom_range(ttrc_pkg::PRINT_LOW, ttrc_pkg::PRINT_HIGH));
    end
    if (bad_char && nlen > 0)
      w[ttrc_pkg::HEADER_BYTES + $urandom_range(0, nlen - 1)] = $urandom_range(0, 1) ?
          ODD_CHARS[$urandom_range(0, 4)] : 8'($urandom_range(0, 8'h1F));
    for (k = 0; k < CHECK_POS; k++) begin
      x ^= w[k];
      record_byte_q.push_back(w[k]);
    end
    if (bad_xor) x ^= 8'($urandom_range(1, 255));
    record_byte_q.push_back(x);
  endtask

  task automatic write_reg(input logic [ttrc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ttrc_pkg::CFG_MAGIC) chk_magic = val;
    else if (idx == ttrc_pkg::CFG_CAPACITY) chk_capacity = val[7:0];
  endtask

  // sender holds off until every queued byte is in and every result is out
  task automatic drain();
    do @(posedge clk);
    while (record_byte_q.size() != 0 || in_valid || expected_text_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) scan_record_byte(data_byte);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (record_byte_q.size() != 0) begin
          in_valid  <= 1'b1;
          data_byte <= record_byte_q.pop_front();
          if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
          in_gap <= in_calm ? 0 : $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_text_q.size() == 0) begin
          report_bad($sformatf("unexpected item char=%h status=%0d last=%b",
                               text_char, status, last));
        end else begin
          want = expected_text_q.pop_front();
          if (text_char !== want.ch || status !== want.st || last !== want.fin)
            report_bad($sformatf("char=%h status=%0d last=%b, expected %h %0d %b",
                                 text_char, status, last, want.ch, want.st, want.fin));
        end
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 6);
      end else begin
        out_stall = out_wait;
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_wait  <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        out_wait  <= 0;
      end
    end
  end

  initial begin
    logic [31:0] magic;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset registers: magic 0, capacity 255
    add_record(32'h0, 32'(TEXT_LEN), 1'b0, 1'b0);
    add_record(32'h0, 32'h0000_0105, 1'b0, 1'b0);        // length upper bytes set
    add_record(32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1);        // magic ranks above length
    add_record(32'h0, 32'(TEXT_LEN + 1), 1'b0, 1'b1);    // length ranks above XOR
    add_record(32'h0, 32'd12, 1'b1, 1'b1);               // XOR ranks above printable
    add_record(32'h0, 32'd12, 1'b1, 1'b0);
    drain();

    // capacity below 2 outranks everything
    magic = $urandom;
    write_reg(ttrc_pkg::CFG_MAGIC, magic);
    write_reg(ttrc_pkg::CFG_CAPACITY, 32'd0);
    add_record(magic, 32'd4, 1'b0, 1'b0);
    drain();

    // capacity boundary: length + 1 must fit
    write_reg(ttrc_pkg::CFG_CAPACITY, 32'd2);
    add_record(magic, 32'd1, 1'b0, 1'b0);                // junk past the length
    add_record(magic, 32'd2, 1'b0, 1'b0);
    drain();

    repeat (10) @(posedge clk);
    if (bad_count == 0 && expected_text_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ttrc_pkg.sv
rtl/ttrc_text_ram.sv
rtl/ttrc_scan.sv
rtl/ttrc_emit.sv
rtl/tagged_text_record_checker.sv
rtl/ttrc_checker.sv
sim/tb.sv
